[rtl/core/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms with a clock and an active-low reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain check with a fixed report text
`define DRPI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("drpi assertion failed");

// Check with a report text of its own
`define DRPI_ASSERT_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

[rtl/core/drpi_pkg.sv]
// ---------------------------------------------------------------------------
// drpi_pkg
// Widths, constants and helper functions of the pose integrator.
// ---------------------------------------------------------------------------
`default_nettype none

package drpi_pkg;

    localparam int DIGIT_W     = 4;
    localparam int SPEED_W     = 24;
    localparam int RATE_W      = 24;
    localparam int DT_W        = 20;
    localparam int DT_EXT_W    = 24;
    localparam int PROD1_W     = RATE_W + DT_EXT_W;
    localparam int DIST_W      = 29;
    localparam int DIST_EXT_W  = 32;
    localparam int CORDIC_W    = 32;
    localparam int PROD2_W     = CORDIC_W + DIST_EXT_W;
    localparam int DELTA_W     = 34;
    localparam int POS_W       = 32;
    localparam int HEAD_W      = 31;
    localparam int QUAT_W      = 16;
    localparam int QSUM_W      = CORDIC_W + 1;
    localparam int QRND_W      = QSUM_W - 15;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 128;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_IDX_W       = 5;

    localparam int WRAP_STEPS = 11;
    localparam int WRAP_W     = 42;
    localparam int WRAP_CNT_W = $clog2(WRAP_STEPS + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE    = 2'd1;

    localparam logic signed [SPEED_W-1:0] SPEED_RST = 24'sd13107;
    localparam logic signed [RATE_W-1:0]  RATE_RST  = 24'sd26214;

    localparam logic signed [CORDIC_W-1:0] PI_Q28          = 32'sd843314857;
    localparam logic signed [CORDIC_W-1:0] HALF_PI_Q28     = 32'sd421657428;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 32'sd652032874;
    localparam logic [63:0]                TWO_PI_Q28_64   = 64'd1686629713;

    // First divisor of the remainder sweep: 2*pi scaled up by 2^(steps-1)
    localparam logic [WRAP_W-1:0] WRAP_DIV0 =
        WRAP_W'(TWO_PI_Q28_64 << (WRAP_STEPS - 1));
    // 16 * (pi + 2*pi*2^(steps-1)) + 8: bias that makes the sum non-negative,
    // with the half-up rounding of the heading step folded in
    localparam logic signed [PROD1_W-1:0] WRAP_BIAS16 =
        PROD1_W'((((TWO_PI_Q28_64 << (WRAP_STEPS - 1)) + 64'd843314857) << 4) + 64'd8);

    function automatic logic signed [CORDIC_W-1:0] atan_q28(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:  v = 32'sd210828714;
            5'd1:  v = 32'sd124459457;
            5'd2:  v = 32'sd65760959;
            5'd3:  v = 32'sd33381290;
            5'd4:  v = 32'sd16755422;
            5'd5:  v = 32'sd8385879;
            5'd6:  v = 32'sd4193963;
            5'd7:  v = 32'sd2097109;
            5'd8:  v = 32'sd1048571;
            5'd9:  v = 32'sd524287;
            5'd10: v = 32'sd262144;
            5'd11: v = 32'sd131072;
            5'd12: v = 32'sd65536;
            5'd13: v = 32'sd32768;
            5'd14: v = 32'sd16384;
            5'd15: v = 32'sd8192;
            5'd16: v = 32'sd4096;
            5'd17: v = 32'sd2048;
            5'd18: v = 32'sd1024;
            5'd19: v = 32'sd512;
            5'd20: v = 32'sd256;
            5'd21: v = 32'sd128;
            5'd22: v = 32'sd64;
            5'd23: v = 32'sd32;
            5'd24: v = 32'sd16;
            5'd25: v = 32'sd8;
            5'd26: v = 32'sd4;
            5'd27: v = 32'sd2;
            5'd28: v = 32'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [POS_W-1:0] sat32(input logic signed [DELTA_W-1:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    function automatic logic signed [QUAT_W-1:0] sat16(input logic signed [QRND_W-1:0] v);
        logic signed [QUAT_W-1:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[QUAT_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/drpi_ser_mul.sv]
// ---------------------------------------------------------------------------
// drpi_ser_mul
// Digit-serial signed multiplier, one multiplier digit per cycle, MSB first.
// ---------------------------------------------------------------------------
`default_nettype none

module drpi_ser_mul #(
    parameter int A_W = drpi_pkg::RATE_W,
    parameter int B_W = drpi_pkg::DT_EXT_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic signed [A_W-1:0]  i_a,
    input  logic signed [B_W-1:0]  i_b,
    output logic                   o_done,
    output logic signed [A_W+B_W-1:0] o_prod
);
    import drpi_pkg::*;

    localparam int P_W   = A_W + B_W;
    localparam int N_DIG = B_W / DIGIT_W;
    localparam int CNT_W = $clog2(N_DIG + 1);

    logic signed [A_W-1:0]         r_a;
    logic [B_W-1:0]                r_b;
    logic signed [P_W-1:0]         r_acc;
    logic [CNT_W-1:0]              r_cnt;
    logic                          r_done;
    logic [DIGIT_W-1:0]            w_digit;
    logic signed [DIGIT_W:0]       w_digit_ext;
    logic signed [A_W+DIGIT_W:0]   w_partial;
    logic signed [P_W-1:0]         n_acc;

    // Top digit carries the sign, the rest are plain magnitudes
    assign w_digit     = r_b[B_W-1 -: DIGIT_W];
    assign w_digit_ext = (r_cnt == CNT_W'(N_DIG)) ? $signed({w_digit[DIGIT_W-1], w_digit})
                                                  : $signed({1'b0, w_digit});
    assign w_partial   = r_a * w_digit_ext;
    assign n_acc       = (r_acc <<< DIGIT_W) + P_W'(w_partial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_W'(N_DIG);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_cnt != '0) begin
            r_b   <= r_b << DIGIT_W;
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

[rtl/core/drpi_wrap.sv]
// ---------------------------------------------------------------------------
// drpi_wrap
// Heading update and wrap into [-pi, pi) by a restoring remainder sweep.
// ---------------------------------------------------------------------------
`default_nettype none

module drpi_wrap (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic signed [drpi_pkg::PROD1_W-1:0]    i_prod,
    input  logic signed [drpi_pkg::CORDIC_W-1:0]   i_head,
    output logic                                   o_done,
    output logic signed [drpi_pkg::CORDIC_W-1:0]   o_heading
);
    import drpi_pkg::*;

    logic [WRAP_W-1:0]          r_rem;
    logic [WRAP_W-1:0]          r_div;
    logic [WRAP_CNT_W-1:0]      r_cnt;
    logic                       r_done;
    logic signed [PROD1_W-1:0]  w_sum16;
    logic [WRAP_W-1:0]          n_rem;

    // Rounded step plus old heading plus bias, still scaled by 16
    assign w_sum16 = i_prod + (PROD1_W'(i_head) <<< 4) + WRAP_BIAS16;
    assign n_rem   = (r_rem >= r_div) ? (r_rem - r_div) : r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= WRAP_CNT_W'(WRAP_STEPS);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - WRAP_CNT_W'(1);
                if (r_cnt == WRAP_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_sum16[WRAP_W+3:4];
            r_div <= WRAP_DIV0;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_div <= r_div >> 1;
        end
    end

    assign o_done    = r_done;
    assign o_heading = $signed({1'b0, r_rem[HEAD_W-1:0]}) - PI_Q28;

endmodule

`default_nettype wire

[rtl/core/drpi_cordic.sv]
// ---------------------------------------------------------------------------
// drpi_cordic
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module drpi_cordic #(
    parameter int STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [drpi_pkg::CORDIC_W-1:0] i_angle,
    output logic                                 o_done,
    output logic signed [drpi_pkg::CORDIC_W-1:0] o_cos,
    output logic signed [drpi_pkg::CORDIC_W-1:0] o_sin
);
    import drpi_pkg::*;

    localparam int IW = $clog2(STEPS);

    logic                        r_busy;
    logic                        r_done;
    logic [IW-1:0]               r_iter;
    logic signed [CORDIC_W-1:0]  r_x;
    logic signed [CORDIC_W-1:0]  r_y;
    logic signed [CORDIC_W-1:0]  r_z;
    logic signed [CORDIC_W-1:0]  w_xs;
    logic signed [CORDIC_W-1:0]  w_ys;
    logic signed [CORDIC_W-1:0]  w_atan;

    assign w_xs   = r_x >>> r_iter;
    assign w_ys   = r_y >>> r_iter;
    assign w_atan = atan_q28(ATAN_IDX_W'(r_iter));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_iter <= '0;
            end else if (r_busy) begin
                if (r_iter == IW'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_iter <= r_iter + IW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= CORDIC_GAIN_Q30;
            r_y <= '0;
            r_z <= i_angle;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end else begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_x;
    assign o_sin  = r_y;

endmodule

`default_nettype wire

[rtl/core/dead_reckoning_pose_integrator.sv]
// ---------------------------------------------------------------------------
// Dead-reckoning pose integrator. A new tick is taken only once the last one is done with its
// two digit-serial multiplies, the 11-step heading remainder and the CORDIC loop; a result may
// wait in the output register while the next tick runs.
// Synchronous active-low reset: pose and heading to zero, registers to 0.2 m/s and 0.4 rad/s.
// ---------------------------------------------------------------------------
`default_nettype none

module dead_reckoning_pose_integrator #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // Tick words in
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [drpi_pkg::IN_TDATA_W-1:0]        s_axis_tdata,  // [19:0] elapsed_time
    // Pose words out
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [drpi_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,  // [31:0] pos_x,
                                                                  // [63:32] pos_y,
                                                                  // [94:64] heading,
                                                                  // [110:95] quat_z,
                                                                  // [126:111] quat_w
    // Register writes
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [drpi_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [drpi_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import drpi_pkg::*;

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_WRAP = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_CORD = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]                  r_state;
    logic [2:0]                  n_state;

    // Configuration and pose state
    logic signed [SPEED_W-1:0]   r_speed;
    logic signed [RATE_W-1:0]    r_rate;
    logic signed [POS_W-1:0]     r_x_acc;
    logic signed [POS_W-1:0]     r_y_acc;
    logic signed [CORDIC_W-1:0]  r_head_acc;

    // Per-tick working registers
    logic signed [CORDIC_W-1:0]  r_head;
    logic                        r_neg;
    logic signed [DIST_W-1:0]    r_dist;
    logic signed [DELTA_W-1:0]   r_dx;
    logic signed [DELTA_W-1:0]   r_dy;

    // Output register
    logic                        r_out_valid;
    logic [OUT_TDATA_W-1:0]      r_out_data;

    logic                        w_accept;
    logic                        w_fire;
    logic signed [DT_EXT_W-1:0]  w_dt_ext;

    logic                        w_mul1_done;
    logic signed [PROD1_W-1:0]   w_prod_rate;
    logic signed [PROD1_W-1:0]   w_prod_speed;
    logic signed [PROD1_W-1:0]   w_dist_sum;

    logic                        w_wrap_done;
    logic signed [CORDIC_W-1:0]  w_wrap_head;

    logic signed [CORDIC_W-1:0]  w_red_angle;
    logic                        w_red_neg;
    logic signed [CORDIC_W-1:0]  w_half_angle;
    logic                        w_cord_done;
    logic signed [CORDIC_W-1:0]  w_cos;
    logic signed [CORDIC_W-1:0]  w_sin;
    logic signed [CORDIC_W-1:0]  w_half_cos;
    logic signed [CORDIC_W-1:0]  w_half_sin;

    logic signed [CORDIC_W-1:0]  w_cos_dir;
    logic signed [CORDIC_W-1:0]  w_sin_dir;
    logic signed [DIST_EXT_W-1:0] w_dist_ext;
    logic                        w_mul2_done;
    logic signed [PROD2_W-1:0]   w_prod_x;
    logic signed [PROD2_W-1:0]   w_prod_y;
    logic signed [PROD2_W-1:0]   w_rnd_x;
    logic signed [PROD2_W-1:0]   w_rnd_y;

    logic signed [DELTA_W-1:0]   w_x_sum;
    logic signed [DELTA_W-1:0]   w_y_sum;
    logic signed [POS_W-1:0]     w_x_new;
    logic signed [POS_W-1:0]     w_y_new;
    logic signed [QSUM_W-1:0]    w_qz_sum;
    logic signed [QSUM_W-1:0]    w_qw_sum;
    logic signed [QUAT_W-1:0]    w_quat_z;
    logic signed [QUAT_W-1:0]    w_quat_w;

    // -----------------------------------------------------------------------
    // Handshakes: take a tick only when the sequencer is idle; the output
    // register frees the sequencer from the downstream side, so the next tick
    // may run while the previous pose still waits to be taken.
    // Register writes are taken only while idle and win over a tick offered
    // in the same cycle, so every tick sees the settings written before it.
    // -----------------------------------------------------------------------
    assign s_axis_tready = (r_state == S_IDLE) & ~i_cfg_valid;
    assign w_accept      = s_axis_tvalid & s_axis_tready;
    assign w_fire        = (r_state == S_DONE) & (~r_out_valid | m_axis_tready);
    assign o_cfg_ready   = (r_state == S_IDLE);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // -----------------------------------------------------------------------
    // Stage 1: rate*dt and speed*dt, both digit-serial over the elapsed time.
    // The time is zero-extended so the top digit is a plain zero.
    // -----------------------------------------------------------------------
    assign w_dt_ext = $signed(DT_EXT_W'(s_axis_tdata[DT_W-1:0]));

    drpi_ser_mul #(
        .A_W (RATE_W),
        .B_W (DT_EXT_W)
    ) u_mul_rate (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_a     (r_rate),
        .i_b     (w_dt_ext),
        .o_done  (w_mul1_done),
        .o_prod  (w_prod_rate)
    );

    drpi_ser_mul #(
        .A_W (SPEED_W),
        .B_W (DT_EXT_W)
    ) u_mul_speed (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_a     (r_speed),
        .i_b     (w_dt_ext),
        .o_done  (),
        .o_prod  (w_prod_speed)
    );

    // Distance: round Q32 to Q16, half up
    assign w_dist_sum = w_prod_speed + PROD1_W'(32768);

    // -----------------------------------------------------------------------
    // Stage 2: new heading, wrapped into [-pi, pi) by a remainder sweep.
    // The rounding of the step and the old heading are folded into its load.
    // -----------------------------------------------------------------------
    drpi_wrap u_wrap (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   ((r_state == S_MUL1) & w_mul1_done),
        .i_prod    (w_prod_rate),
        .i_head    (r_head_acc),
        .o_done    (w_wrap_done),
        .o_heading (w_wrap_head)
    );

    // -----------------------------------------------------------------------
    // Stage 3: fold the heading into +-pi/2 for the full-angle CORDIC (flip
    // both results afterwards) and run the half-angle CORDIC alongside; the
    // half angle is already within range.
    // -----------------------------------------------------------------------
    always_comb begin
        w_red_angle = r_head;
        w_red_neg   = 1'b0;
        if (r_head > HALF_PI_Q28) begin
            w_red_angle = r_head - PI_Q28;
            w_red_neg   = 1'b1;
        end else if (r_head < -HALF_PI_Q28) begin
            w_red_angle = r_head + PI_Q28;
            w_red_neg   = 1'b1;
        end
    end

    assign w_half_angle = r_head >>> 1;

    drpi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_full (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_angle (w_red_angle),
        .o_done  (w_cord_done),
        .o_cos   (w_cos),
        .o_sin   (w_sin)
    );

    drpi_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_PREP),
        .i_angle (w_half_angle),
        .o_done  (),
        .o_cos   (w_half_cos),
        .o_sin   (w_half_sin)
    );

    // -----------------------------------------------------------------------
    // Stage 4: dist*cos and dist*sin, digit-serial over the distance
    // -----------------------------------------------------------------------
    assign w_cos_dir  = r_neg ? -w_cos : w_cos;
    assign w_sin_dir  = r_neg ? -w_sin : w_sin;
    assign w_dist_ext = DIST_EXT_W'(r_dist);

    drpi_ser_mul #(
        .A_W (CORDIC_W),
        .B_W (DIST_EXT_W)
    ) u_mul_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_CORD) & w_cord_done),
        .i_a     (w_cos_dir),
        .i_b     (w_dist_ext),
        .o_done  (w_mul2_done),
        .o_prod  (w_prod_x)
    );

    drpi_ser_mul #(
        .A_W (CORDIC_W),
        .B_W (DIST_EXT_W)
    ) u_mul_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start ((r_state == S_CORD) & w_cord_done),
        .i_a     (w_sin_dir),
        .i_b     (w_dist_ext),
        .o_done  (),
        .o_prod  (w_prod_y)
    );

    // Round Q46 to Q16, half up
    assign w_rnd_x = w_prod_x + PROD2_W'(64'd536870912);
    assign w_rnd_y = w_prod_y + PROD2_W'(64'd536870912);

    // -----------------------------------------------------------------------
    // Stage 5: saturating position update and quaternion terms
    // -----------------------------------------------------------------------
    assign w_x_sum  = DELTA_W'(r_x_acc) + r_dx;
    assign w_y_sum  = DELTA_W'(r_y_acc) + r_dy;
    assign w_x_new  = sat32(w_x_sum);
    assign w_y_new  = sat32(w_y_sum);

    // Q30 to Q15, half up, clipped (cos of zero lands on full scale)
    assign w_qz_sum = QSUM_W'(w_half_sin) + QSUM_W'(16384);
    assign w_qw_sum = QSUM_W'(w_half_cos) + QSUM_W'(16384);
    assign w_quat_z = sat16(w_qz_sum[QSUM_W-1:15]);
    assign w_quat_w = sat16(w_qw_sum[QSUM_W-1:15]);

    // -----------------------------------------------------------------------
    // Sequencer
    // -----------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept)    n_state = S_MUL1;
            S_MUL1: if (w_mul1_done) n_state = S_WRAP;
            S_WRAP: if (w_wrap_done) n_state = S_PREP;
            S_PREP:                  n_state = S_CORD;
            S_CORD: if (w_cord_done) n_state = S_MUL2;
            S_MUL2: if (w_mul2_done) n_state = S_DONE;
            S_DONE: if (w_fire)      n_state = S_IDLE;
            default:                 n_state = S_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_speed     <= SPEED_RST;
            r_rate      <= RATE_RST;
            r_x_acc     <= '0;
            r_y_acc     <= '0;
            r_head_acc  <= '0;
        end else begin
            r_state <= n_state;

            // Register writes arrive only while idle; drop unknown indexes
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_LINEAR_SPEED: r_speed <= $signed(i_cfg_data);
                    REG_TURN_RATE:    r_rate  <= $signed(i_cfg_data);
                    default:          ;
                endcase
            end

            // Commit the pose together with the word that reports it
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_x_acc     <= w_x_new;
                r_y_acc     <= w_y_new;
                r_head_acc  <= r_head;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers: hold between stages, no reset needed
    always_ff @(posedge i_clk) begin
        if ((r_state == S_MUL1) && w_mul1_done) begin
            r_dist <= w_dist_sum[DIST_W+15:16];
        end
        if ((r_state == S_WRAP) && w_wrap_done) begin
            r_head <= w_wrap_head;
        end
        if (r_state == S_PREP) begin
            r_neg <= w_red_neg;
        end
        if ((r_state == S_MUL2) && w_mul2_done) begin
            r_dx <= w_rnd_x[PROD2_W-1:30];
            r_dy <= w_rnd_y[PROD2_W-1:30];
        end
        if (w_fire) begin
            r_out_data <= {1'b0, w_quat_w, w_quat_z, r_head[HEAD_W-1:0], w_y_new, w_x_new};
        end
    end

endmodule

`default_nettype wire

[rtl/core/drpi_checker.sv]
// ---------------------------------------------------------------------------
// drpi_port_checker
// Port-level checks on the pose integrator, attached by bind.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module drpi_port_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [drpi_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import drpi_pkg::*;

    localparam int HEAD_LSB = 2 * POS_W;

    logic signed [HEAD_W-1:0] w_head;
    logic                     w_in_hs;
    logic                     w_out_stall;
    logic                     w_head_ok;

    assign w_head      = $signed(m_axis_tdata[HEAD_LSB +: HEAD_W]);
    assign w_in_hs     = s_axis_tvalid & s_axis_tready;
    assign w_out_stall = m_axis_tvalid & ~m_axis_tready;
    assign w_head_ok   = (w_head >= -PI_Q28) && (w_head < PI_Q28);

    // One tick in flight: ready drops straight after a tick is taken
    `DRPI_ASSERT(a_busy_after_take, i_clk, i_rst_n, w_in_hs |=> !s_axis_tready)

    // A new pose word only ever shows while a tick was being worked on
    `DRPI_ASSERT(a_word_from_work, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> $past(!s_axis_tready))

    // Reported heading stays wrapped into [-pi, pi)
    `DRPI_ASSERT_MSG(a_head_wrapped, i_clk, i_rst_n, m_axis_tvalid |-> w_head_ok, "heading unwrapped")

    // A stalled pose word holds
    `DRPI_ASSERT(a_out_hold, i_clk, i_rst_n, w_out_stall |=> (m_axis_tvalid && $stable(m_axis_tdata)))

endmodule

bind dead_reckoning_pose_integrator drpi_port_checker u_drpi_checker (.*);

`default_nettype wire

[test/drpi_checker.sv]
// ---------------------------------------------------------------------------
// drpi_checker
// Watches the tick, pose and register channels of the pose integrator. Keeps
// its own fixed-point copy of heading, position and registers, predicts the
// pose word for every accepted tick and compares it field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module drpi_checker #(
    parameter int CORDIC_STEPS = drpi_pkg::CORDIC_STEPS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_tick_valid,
    input  logic                               i_tick_ready,
    input  logic [drpi_pkg::IN_TDATA_W-1:0]    i_tick_data,
    input  logic                               i_pose_valid,
    input  logic                               i_pose_ready,
    input  logic [drpi_pkg::OUT_TDATA_W-1:0]   i_pose_data,
    input  logic                               i_cfg_valid,
    input  logic                               i_cfg_ready,
    input  logic [drpi_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [drpi_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import drpi_pkg::*;

    localparam longint PI_RAD      = 843314857;
    localparam longint TWO_PI_RAD  = 1686629713;
    localparam longint HALF_PI_RAD = 421657428;
    localparam longint VEC_GAIN    = 652032874;
    localparam longint POS_MAX     = 64'sh7FFF_FFFF;
    localparam longint POS_MIN     = -64'sh8000_0000;
    localparam longint Q15_MAX     = 32767;
    localparam longint Q15_MIN     = -32768;
    localparam int     ANGLE_ROWS  = 30;

    localparam longint ANGLE_STEP_Q28 [ANGLE_ROWS] = '{
        210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
        4193963, 2097109, 1048571, 524287, 262144, 131072, 65536, 32768,
        16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0
    };

    typedef struct packed {
        logic signed [POS_W-1:0]  pos_x;
        logic signed [POS_W-1:0]  pos_y;
        logic signed [HEAD_W-1:0] heading;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
    } t_pose;

    logic signed [SPEED_W-1:0] speed_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    longint                    x_pos;
    longint                    y_pos;
    longint                    yaw;
    t_pose                     pending_poses [$];
    int                        fails = 0;

    function automatic longint round_half_up(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Rotation-mode CORDIC: angle Q28, cosine and sine Q30
    function automatic void rotate(input longint ang, output longint c, output longint s);
        longint vx, vy, vz, sx, sy;
        vx = VEC_GAIN;
        vy = 0;
        vz = ang;
        for (int i = 0; i < CORDIC_STEPS && i < ANGLE_ROWS; i++) begin
            sx = vx >>> i;
            sy = vy >>> i;
            if (vz >= 0) begin
                vx = vx - sy;
                vy = vy + sx;
                vz = vz - ANGLE_STEP_Q28[i];
            end else begin
                vx = vx + sy;
                vy = vy - sx;
                vz = vz + ANGLE_STEP_Q28[i];
            end
        end
        c = vx;
        s = vy;
    endfunction

    // Advance heading and position by one tick and form the pose word
    function automatic t_pose advance_pose(input logic [DT_W-1:0] dt);
        longint dt_l, turn, spd, h, r, c, s, span, hc, hs;
        logic   flip;
        t_pose  p;
        dt_l = dt;
        turn = rate_reg;
        spd  = speed_reg;

        h = yaw + round_half_up(turn * dt_l, 4);
        r = (h + PI_RAD) % TWO_PI_RAD;
        if (r < 0) begin
            r = r + TWO_PI_RAD;
        end
        h   = r - PI_RAD;
        yaw = h;

        // Fold the heading into +-pi/2 and flip the vector back afterwards
        flip = 1'b0;
        if (h > HALF_PI_RAD) begin
            r    = h - PI_RAD;
            flip = 1'b1;
        end else if (h < -HALF_PI_RAD) begin
            r    = h + PI_RAD;
            flip = 1'b1;
        end else begin
            r = h;
        end
        rotate(r, c, s);
        if (flip) begin
            c = -c;
            s = -s;
        end

        span  = round_half_up(spd * dt_l, 16);
        x_pos = clamp(x_pos + round_half_up(span * c, 30), POS_MIN, POS_MAX);
        y_pos = clamp(y_pos + round_half_up(span * s, 30), POS_MIN, POS_MAX);

        rotate(h >>> 1, hc, hs);

        p.pos_x   = POS_W'(x_pos);
        p.pos_y   = POS_W'(y_pos);
        p.heading = HEAD_W'(h);
        p.quat_z  = QUAT_W'(clamp(round_half_up(hs, 15), Q15_MIN, Q15_MAX));
        p.quat_w  = QUAT_W'(clamp(round_half_up(hc, 15), Q15_MIN, Q15_MAX));
        return p;
    endfunction

    function automatic void check_field(input string label, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_pose want, got;
        if (!i_rst_n) begin
            speed_reg = SPEED_RST;
            rate_reg  = RATE_RST;
            x_pos     = 0;
            y_pos     = 0;
            yaw       = 0;
            pending_poses.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_LINEAR_SPEED: speed_reg = i_cfg_data;
                    REG_TURN_RATE:    rate_reg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_tick_valid && i_tick_ready) begin
                pending_poses.push_back(advance_pose(i_tick_data[DT_W-1:0]));
            end
            if (i_pose_valid && i_pose_ready) begin
                got.pos_x   = i_pose_data[31:0];
                got.pos_y   = i_pose_data[63:32];
                got.heading = i_pose_data[94:64];
                got.quat_z  = i_pose_data[110:95];
                got.quat_w  = i_pose_data[126:111];
                if (pending_poses.size() == 0) begin
                    $display("%0t: pose word with none expected: expected nothing, actual %h",
                             $time, i_pose_data);
                    fails++;
                end else begin
                    want = pending_poses.pop_front();
                    check_field("pos_x", $signed(want.pos_x), $signed(got.pos_x));
                    check_field("pos_y", $signed(want.pos_y), $signed(got.pos_y));
                    check_field("heading", $signed(want.heading), $signed(got.heading));
                    check_field("quat_z", $signed(want.quat_z), $signed(got.quat_z));
                    check_field("quat_w", $signed(want.quat_w), $signed(got.quat_w));
                end
            end
        end
        o_pending    <= pending_poses.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

[test/tb_top.sv]
// ---------------------------------------------------------------------------
// tb_top
// Drives ticks and register writes into the pose integrator: a directed
// opening (zero and full elapsed time, position saturation, heading wrap,
// writes to unused indexes) and then random phases, each under fresh speed
// and turn-rate settings, with random idling on both streams. The checker
// beside the block predicts every pose word; this module gives the verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import drpi_pkg::*;

    localparam int STEPS       = CORDIC_STEPS_DEF;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 47;
    localparam int SETTLE      = 60;    // comfortably past the work on one tick

    // Indexes past the register list; the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [DT_W-1:0]       DT_NONE  = '0;
    localparam logic [DT_W-1:0]       DT_MAX   = '1;
    localparam logic [DT_W-1:0]       DT_LSB   = 20'd1;
    localparam logic [CFG_DATA_W-1:0] CFG_MAX  = 24'h7F_FFFF;
    localparam logic [CFG_DATA_W-1:0] CFG_MIN  = 24'h80_0000;
    localparam logic [CFG_DATA_W-1:0] CFG_ZERO = '0;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;     // [19:0] elapsed_time
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;     // pos_x, pos_y, heading, quat_z, quat_w
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int fail_count;
    int pending;
    int gap_odds;      // 1-in-N chance of a sender gap after a word; 0 holds off gaps
    int stall_odds;    // 1-in-N chance per cycle of a receiver stall; 0 holds off stalls

    always #10 i_clk = ~i_clk;

    dead_reckoning_pose_integrator #(
        .CORDIC_STEPS (STEPS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    drpi_checker #(
        .CORDIC_STEPS (STEPS)
    ) checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick_valid (s_axis_tvalid),
        .i_tick_ready (s_axis_tready),
        .i_tick_data  (s_axis_tdata),
        .i_pose_valid (m_axis_tvalid),
        .i_pose_ready (m_axis_tready),
        .i_pose_data  (m_axis_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver side: stall in random bursts, as often as the phase allows
    initial begin
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Hold the tick word until it is taken, then maybe leave a gap
    task automatic send_tick(input logic [DT_W-1:0] dt);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - DT_W){1'b0}}, dt};
        do @(posedge i_clk); while (!s_axis_tready);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // Every tick gives one pose word, so the block is idle once none is outstanding
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mostly short ticks as at tens of hertz, with zero, full-scale and wide values
    function automatic logic [DT_W-1:0] random_dt();
        case ($urandom_range(0, 19))
            0:          return DT_NONE;
            1:          return DT_MAX;
            2, 3, 4, 5: return DT_W'($urandom());
            default:    return DT_W'($urandom_range(1, 8191));
        endcase
    endfunction

    // Extremes, full-range values and moderate values of a few units either side of zero
    function automatic logic [CFG_DATA_W-1:0] random_setting();
        case ($urandom_range(0, 9))
            0:       return CFG_MAX;
            1:       return CFG_MIN;
            2:       return CFG_ZERO;
            3, 4, 5: return CFG_DATA_W'($urandom());
            default: return CFG_DATA_W'($urandom_range(0, 1 << 19) - (1 << 18));
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            2:       return 10;
            default: return 40;
        endcase
    endfunction

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_index   <= REG_LINEAR_SPEED;
        i_cfg_data    <= CFG_ZERO;
        gap_odds      <= 0;
        stall_odds    <= 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero elapsed time straight after reset: the reset pose comes back
        send_tick(DT_NONE);
        drain();

        // Straight run at full speed: x climbs by about 2048 m a tick and saturates
        write_reg(REG_TURN_RATE, CFG_ZERO);
        write_reg(REG_LINEAR_SPEED, CFG_MAX);
        repeat (18) send_tick(DT_MAX);
        drain();

        // Full reverse speed with the largest turn steps either way: heading wraps
        write_reg(REG_LINEAR_SPEED, CFG_MIN);
        write_reg(REG_TURN_RATE, CFG_MAX);
        send_tick(DT_MAX);
        send_tick(DT_MAX);
        drain();
        write_reg(REG_TURN_RATE, CFG_MIN);
        send_tick(DT_MAX);
        send_tick(DT_LSB);
        drain();

        // Writes past the register list must leave both settings alone
        write_reg(REG_SPARE_A, CFG_DATA_W'($urandom()));
        write_reg(REG_SPARE_B, CFG_DATA_W'($urandom()));
        send_tick(DT_LSB);
        send_tick(DT_W'(65536));
        drain();

        // Random phases; the last one runs without idling on either side
        for (int ph = 0; ph < PHASES; ph++) begin
            gap_odds   <= (ph == PHASES - 1) ? 0 : pick_odds();
            stall_odds <= (ph == PHASES - 1) ? 0 : pick_odds();
            if ($urandom_range(0, 1) == 0) begin
                write_reg(REG_LINEAR_SPEED, random_setting());
                write_reg(REG_TURN_RATE, random_setting());
            end else begin
                write_reg(REG_TURN_RATE, random_setting());
                write_reg(REG_LINEAR_SPEED, random_setting());
            end
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'($urandom()));
            end
            repeat (PHASE_TICKS + $urandom_range(0, 6)) send_tick(random_dt());
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Abandon a hung run
    initial begin
        #(20 * 400000);
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
